// ===== hdl/epg3d_pkg.sv =====
// shared constants, types and the quarter-wave sine table for the 3-d ellipse point generator
package epg3d_pkg;

    // default configuration
    localparam int POINTS_DEF     = 100;
    localparam int VOL_WIDTH_DEF  = 256;
    localparam int VOL_HEIGHT_DEF = 256;
    localparam int VOL_DEPTH_DEF  = 256;

    // field widths
    localparam int COORD_W  = 13;
    localparam int VOXEL_W  = 15;
    localparam int COLOUR_W = 8;
    localparam int INDEX_W  = 7;
    localparam int PHASE_W  = 16;
    localparam int TRIG_W   = 16;   // signed q1.15, magnitude up to 32767
    localparam int MAG_W    = 15;
    localparam int STEP_W   = 10;   // largest step between table entries is 804
    localparam int PROD_W   = COORD_W + TRIG_W;
    localparam int SUM_W    = 31;

    localparam int S_TDATA_W = 136;
    localparam int M_TDATA_W = 56;

    localparam int AXES = 3;

    // quarter-wave sine, sin(k*pi/128) in q1.15; entries at and beyond a quarter saturate
    function automatic logic [MAG_W-1:0] quarter_sine(input logic [6:0] k);
        logic [MAG_W-1:0] v;
        case (k)
            7'd0:  v = 15'd0;     7'd1:  v = 15'd804;   7'd2:  v = 15'd1608;
            7'd3:  v = 15'd2411;  7'd4:  v = 15'd3212;  7'd5:  v = 15'd4011;
            7'd6:  v = 15'd4808;  7'd7:  v = 15'd5602;  7'd8:  v = 15'd6393;
            7'd9:  v = 15'd7180;  7'd10: v = 15'd7962;  7'd11: v = 15'd8740;
            7'd12: v = 15'd9512;  7'd13: v = 15'd10279; 7'd14: v = 15'd11039;
            7'd15: v = 15'd11793; 7'd16: v = 15'd12540; 7'd17: v = 15'd13279;
            7'd18: v = 15'd14010; 7'd19: v = 15'd14733; 7'd20: v = 15'd15447;
            7'd21: v = 15'd16151; 7'd22: v = 15'd16846; 7'd23: v = 15'd17531;
            7'd24: v = 15'd18205; 7'd25: v = 15'd18868; 7'd26: v = 15'd19520;
            7'd27: v = 15'd20160; 7'd28: v = 15'd20788; 7'd29: v = 15'd21403;
            7'd30: v = 15'd22006; 7'd31: v = 15'd22595; 7'd32: v = 15'd23170;
            7'd33: v = 15'd23732; 7'd34: v = 15'd24279; 7'd35: v = 15'd24812;
            7'd36: v = 15'd25330; 7'd37: v = 15'd25833; 7'd38: v = 15'd26320;
            7'd39: v = 15'd26791; 7'd40: v = 15'd27246; 7'd41: v = 15'd27684;
            7'd42: v = 15'd28106; 7'd43: v = 15'd28511; 7'd44: v = 15'd28899;
            7'd45: v = 15'd29269; 7'd46: v = 15'd29622; 7'd47: v = 15'd29957;
            7'd48: v = 15'd30274; 7'd49: v = 15'd30572; 7'd50: v = 15'd30853;
            7'd51: v = 15'd31114; 7'd52: v = 15'd31357; 7'd53: v = 15'd31581;
            7'd54: v = 15'd31786; 7'd55: v = 15'd31972; 7'd56: v = 15'd32138;
            7'd57: v = 15'd32286; 7'd58: v = 15'd32413; 7'd59: v = 15'd32522;
            7'd60: v = 15'd32610; 7'd61: v = 15'd32679; 7'd62: v = 15'd32729;
            7'd63: v = 15'd32758;
            default: v = 15'd32767;
        endcase
        return v;
    endfunction

    // table position and sign for one phase: fold into the first quadrant
    typedef struct packed {
        logic [MAG_W-1:0]  base;
        logic [STEP_W-1:0] step;
        logic [7:0]        frac;
        logic              neg;
    } trig_interp_t;

    function automatic trig_interp_t fold_phase(input logic [PHASE_W-1:0] ph);
        trig_interp_t r;
        logic [14:0] pos;
        logic [MAG_W-1:0] lo;
        logic [MAG_W-1:0] hi;
        pos = ph[14] ? (15'd16384 - {1'b0, ph[13:0]}) : {1'b0, ph[13:0]};
        lo = quarter_sine(pos[14:8]);
        hi = quarter_sine(pos[14:8] + 7'd1);
        r.base = lo;
        r.step = STEP_W'(hi - lo);
        r.frac = pos[7:0];
        r.neg  = ph[15];
        return r;
    endfunction

endpackage

// ===== hdl/ellipse_point_generator_3d_core.sv =====
// top level: pipelined 3-d ellipse point generator
//
// Input stream s_*: one request per sample point, carrying the ellipse centre,
// the cosine and sine axis vectors, a colour and the point index. Each request
// gives exactly one result on m_*: the voxel coordinate
// cos(t)*major + sin(t)*minor + centre, each component truncated toward zero,
// the colour, and a write enable in m_tuser that is set when the point lies
// inside the volume (z below the last depth plane).
// The angle t follows from the point index through a constant phase table;
// sine and cosine come from an interpolated quarter-wave table in q1.15.
// The pipeline takes one request every cycle while s_tready is high. The six
// stages are: phase lookup, quadrant fold and table read, interpolation, the
// six axis multiplies, the three sums, and the truncation with bounds check
// into the output register, which drives m_tvalid.
// Each stage has its own valid bit and loads whenever it is empty or the next
// stage can move, so bubbles close up while m_tready is low and s_tready only
// falls once all six stages hold a result. Nothing is dropped or repeated.
// Reset (aresetn low, synchronous) empties the pipeline; in-flight requests
// are discarded.
module ellipse_point_generator_3d_core #(
    parameter int POINTS     = epg3d_pkg::POINTS_DEF,
    parameter int VOL_WIDTH  = epg3d_pkg::VOL_WIDTH_DEF,
    parameter int VOL_HEIGHT = epg3d_pkg::VOL_HEIGHT_DEF,
    parameter int VOL_DEPTH  = epg3d_pkg::VOL_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // centre_x, centre_y, centre_z, major_x, major_y, major_z,
    // minor_x, minor_y, minor_z, colour, point_index, zero pad
    input  logic [epg3d_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // voxel_x, voxel_y, voxel_z, voxel_colour, zero pad
    output logic [epg3d_pkg::M_TDATA_W-1:0]  m_tdata,
    // write_enable
    output logic [0:0]                       m_tuser
);

    localparam int CW    = epg3d_pkg::COORD_W;
    localparam int VW    = epg3d_pkg::VOXEL_W;
    localparam int KW    = epg3d_pkg::COLOUR_W;
    localparam int IW    = epg3d_pkg::INDEX_W;
    localparam int PW    = epg3d_pkg::PHASE_W;
    localparam int TW    = epg3d_pkg::TRIG_W;
    localparam int MW    = epg3d_pkg::MAG_W;
    localparam int QW    = epg3d_pkg::PROD_W;
    localparam int SW    = epg3d_pkg::SUM_W;
    localparam int NA    = epg3d_pkg::AXES;
    localparam int NSTG  = 6;
    localparam int NIDX  = 1 << IW;
    localparam int PAD_M = epg3d_pkg::M_TDATA_W - (3 * VW + KW);

    localparam logic signed [VW:0] X_LIM = (VW+1)'(VOL_WIDTH);
    localparam logic signed [VW:0] Y_LIM = (VW+1)'(VOL_HEIGHT);
    localparam logic signed [VW:0] Z_LIM = (VW+1)'(VOL_DEPTH - 1);

    // stage handshake
    logic [NSTG:1] valid_reg;
    logic [NSTG:1] valid_next;
    logic [NSTG+1:1] ready;
    logic [NSTG-1:0] valid_in;

    // request unpack
    logic signed [CW-1:0] in_centre [NA];
    logic signed [CW-1:0] in_major  [NA];
    logic signed [CW-1:0] in_minor  [NA];
    logic [KW-1:0]        in_colour;
    logic [IW-1:0]        in_index;

    // phase table, one entry per possible index
    logic [PW-1:0] phase_lut [NIDX];

    // stage 1
    logic [PW-1:0]        phase_reg;
    logic signed [CW-1:0] centre1_reg [NA];
    logic signed [CW-1:0] major1_reg  [NA];
    logic signed [CW-1:0] minor1_reg  [NA];
    logic [KW-1:0]        colour1_reg;

    // stage 2
    epg3d_pkg::trig_interp_t sin_fold_reg;
    epg3d_pkg::trig_interp_t cos_fold_reg;
    epg3d_pkg::trig_interp_t sin_fold_next;
    epg3d_pkg::trig_interp_t cos_fold_next;
    logic signed [CW-1:0] centre2_reg [NA];
    logic signed [CW-1:0] major2_reg  [NA];
    logic signed [CW-1:0] minor2_reg  [NA];
    logic [KW-1:0]        colour2_reg;

    // stage 3
    logic signed [TW-1:0] sin_reg;
    logic signed [TW-1:0] cos_reg;
    logic signed [TW-1:0] sin_next;
    logic signed [TW-1:0] cos_next;
    logic signed [CW-1:0] centre3_reg [NA];
    logic signed [CW-1:0] major3_reg  [NA];
    logic signed [CW-1:0] minor3_reg  [NA];
    logic [KW-1:0]        colour3_reg;

    // stage 4
    logic signed [QW-1:0] maj_prod_reg [NA];
    logic signed [QW-1:0] min_prod_reg [NA];
    logic signed [CW-1:0] centre4_reg  [NA];
    logic [KW-1:0]        colour4_reg;

    // stage 5
    logic signed [SW-1:0] sum_reg [NA];
    logic signed [SW-1:0] sum_next [NA];
    logic [KW-1:0]        colour5_reg;

    // stage 6, output register
    logic signed [VW-1:0] voxel_reg [NA];
    logic signed [VW-1:0] voxel_next [NA];
    logic [KW-1:0]        colour6_reg;
    logic                 we_reg;
    logic                 we_next;

    // unpack the request
    always_comb begin
        for (int a = 0; a < NA; a++) begin
            in_centre[a] = s_tdata[a*CW +: CW];
            in_major[a]  = s_tdata[(NA+a)*CW +: CW];
            in_minor[a]  = s_tdata[(2*NA+a)*CW +: CW];
        end
        in_colour = s_tdata[3*NA*CW +: KW];
        in_index  = s_tdata[3*NA*CW+KW +: IW];
    end

    // phase per index: round((POINTS-1-(i mod POINTS))*65536/POINTS), worked out at elaboration
    for (genvar g = 0; g < NIDX; g++) begin : g_phase
        localparam longint unsigned IDX = longint'(g) % longint'(POINTS);
        localparam longint unsigned M   = longint'(POINTS) - 1 - IDX;
        localparam longint unsigned PH  =
            (M * 65536 + longint'(POINTS) / 2) / longint'(POINTS);
        assign phase_lut[g] = PW'(PH % 65536);
    end

    // per-stage ready: a stage loads when it is empty or its successor moves
    always_comb begin
        ready[NSTG+1] = m_tready;
        for (int k = NSTG; k >= 1; k--) begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
        valid_in[0] = s_tvalid;
        for (int k = 1; k < NSTG; k++) begin
            valid_in[k] = valid_reg[k];
        end
        for (int k = 1; k <= NSTG; k++) begin
            valid_next[k] = ready[k] ? valid_in[k-1] : valid_reg[k];
        end
    end

    assign s_tready = ready[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // stage 1: phase lookup
    always_ff @(posedge aclk) begin
        if (ready[1]) begin
            phase_reg   <= phase_lut[in_index];
            centre1_reg <= in_centre;
            major1_reg  <= in_major;
            minor1_reg  <= in_minor;
            colour1_reg <= in_colour;
        end
    end

    // stage 2: quadrant fold and table read for sine and cosine
    always_comb begin
        sin_fold_next = epg3d_pkg::fold_phase(phase_reg);
        cos_fold_next = epg3d_pkg::fold_phase(phase_reg + PW'(16384));
    end

    always_ff @(posedge aclk) begin
        if (ready[2]) begin
            sin_fold_reg <= sin_fold_next;
            cos_fold_reg <= cos_fold_next;
            centre2_reg  <= centre1_reg;
            major2_reg   <= major1_reg;
            minor2_reg   <= minor1_reg;
            colour2_reg  <= colour1_reg;
        end
    end

    // stage 3: linear interpolation, rounded step, then sign
    function automatic logic signed [TW-1:0] interp(input epg3d_pkg::trig_interp_t f);
        logic [17:0] scaled;
        logic [MW-1:0] mag;
        scaled = 18'(f.step) * 18'(f.frac) + 18'd128;
        mag = f.base + MW'(scaled[17:8]);
        return f.neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

    always_comb begin
        sin_next = interp(sin_fold_reg);
        cos_next = interp(cos_fold_reg);
    end

    always_ff @(posedge aclk) begin
        if (ready[3]) begin
            sin_reg     <= sin_next;
            cos_reg     <= cos_next;
            centre3_reg <= centre2_reg;
            major3_reg  <= major2_reg;
            minor3_reg  <= minor2_reg;
            colour3_reg <= colour2_reg;
        end
    end

    // stage 4: axis multiplies, two per component
    always_ff @(posedge aclk) begin
        if (ready[4]) begin
            for (int a = 0; a < NA; a++) begin
                maj_prod_reg[a] <= QW'(major3_reg[a]) * QW'(cos_reg);
                min_prod_reg[a] <= QW'(minor3_reg[a]) * QW'(sin_reg);
            end
            centre4_reg <= centre3_reg;
            colour4_reg <= colour3_reg;
        end
    end

    // stage 5: exact q.15 sum with the centre scaled up
    always_comb begin
        for (int a = 0; a < NA; a++) begin
            sum_next[a] = SW'(maj_prod_reg[a]) + SW'(min_prod_reg[a])
                        + $signed({{(SW-CW-15){centre4_reg[a][CW-1]}}, centre4_reg[a], 15'd0});
        end
    end

    always_ff @(posedge aclk) begin
        if (ready[5]) begin
            sum_reg     <= sum_next;
            colour5_reg <= colour4_reg;
        end
    end

    // stage 6: divide by 32768 toward zero, bounds check
    always_comb begin
        logic signed [SW-1:0] biased;
        for (int a = 0; a < NA; a++) begin
            biased = sum_reg[a] + (sum_reg[a][SW-1] ? SW'(32767) : SW'(0));
            voxel_next[a] = biased[15 +: VW];
        end
        we_next = !voxel_next[0][VW-1] && ($signed({voxel_next[0][VW-1], voxel_next[0]}) < X_LIM)
               && !voxel_next[1][VW-1] && ($signed({voxel_next[1][VW-1], voxel_next[1]}) < Y_LIM)
               && !voxel_next[2][VW-1] && ($signed({voxel_next[2][VW-1], voxel_next[2]}) < Z_LIM);
    end

    always_ff @(posedge aclk) begin
        if (ready[6]) begin
            voxel_reg   <= voxel_next;
            colour6_reg <= colour5_reg;
            we_reg      <= we_next;
        end
    end

    // result
    assign m_tvalid   = valid_reg[NSTG];
    assign m_tdata    = {PAD_M'(0), colour6_reg, voxel_reg[2], voxel_reg[1], voxel_reg[0]};
    assign m_tuser[0] = we_reg;

    // full back-pressure only once every stage holds a result
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (valid_reg == '1))
        else $error("input stalled with an empty pipeline stage");

    // a write enable never goes out with a negative coordinate
    a_we_positive: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (!voxel_reg[0][VW-1] && !voxel_reg[1][VW-1]
                                      && !voxel_reg[2][VW-1]))
        else $error("write enable set for a negative coordinate");

    // the last depth plane is never written
    a_we_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> ($signed({voxel_reg[2][VW-1], voxel_reg[2]}) < Z_LIM))
        else $error("write enable set at or beyond the last depth plane");

    // interpolated sine and cosine stay within q1.15 magnitude
    a_trig_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[3] |-> (sin_reg != $signed({1'b1, {(TW-1){1'b0}}})
                          && cos_reg != $signed({1'b1, {(TW-1){1'b0}}})))
        else $error("sine or cosine out of range");

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for the 3-d ellipse point generator core
`timescale 1ns / 100ps

module tb_top;

    // shared widths and defaults
    localparam int          COORD_W        = epg3d_pkg::COORD_W;
    localparam int          VOXEL_W        = epg3d_pkg::VOXEL_W;
    localparam int          COLOUR_W       = epg3d_pkg::COLOUR_W;
    localparam int          INDEX_W        = epg3d_pkg::INDEX_W;
    localparam int          PHASE_W        = epg3d_pkg::PHASE_W;
    localparam int          S_TDATA_W      = epg3d_pkg::S_TDATA_W;
    localparam int          M_TDATA_W      = epg3d_pkg::M_TDATA_W;
    localparam int          POINTS_DEF     = epg3d_pkg::POINTS_DEF;
    localparam int          VOL_WIDTH_DEF  = epg3d_pkg::VOL_WIDTH_DEF;
    localparam int          VOL_HEIGHT_DEF = epg3d_pkg::VOL_HEIGHT_DEF;
    localparam int          VOL_DEPTH_DEF  = epg3d_pkg::VOL_DEPTH_DEF;

    localparam int          CLK_HALF     = 10;
    localparam int          RESET_CYCLES = 7;
    localparam int          RANDOM_ITEMS = 1100;
    localparam int          DRAIN_CYCLES = 20;
    localparam int          STALL_LIMIT  = 2000;
    localparam int unsigned QUARTER_TURN = 16384;
    localparam int          ONE_Q15      = 32768;
    localparam int          VOXEL_BITS   = 3 * VOXEL_W + COLOUR_W;

    // sin(k*pi/128) in q1.15, last entry saturated
    localparam int SINE_TAB [0:64] = '{
            0,   804,  1608,  2411,  3212,  4011,  4808,  5602,
         6393,  7180,  7962,  8740,  9512, 10279, 11039, 11793,
        12540, 13279, 14010, 14733, 15447, 16151, 16846, 17531,
        18205, 18868, 19520, 20160, 20788, 21403, 22006, 22595,
        23170, 23732, 24279, 24812, 25330, 25833, 26320, 26791,
        27246, 27684, 28106, 28511, 28899, 29269, 29622, 29957,
        30274, 30572, 30853, 31114, 31357, 31581, 31786, 31972,
        32138, 32286, 32413, 32522, 32610, 32679, 32729, 32758,
        32767
    };

    // request fields, centre_x in the lowest bits
    typedef struct packed {
        logic [INDEX_W-1:0]         point_index;
        logic [COLOUR_W-1:0]        colour;
        logic signed [COORD_W-1:0]  minor_z;
        logic signed [COORD_W-1:0]  minor_y;
        logic signed [COORD_W-1:0]  minor_x;
        logic signed [COORD_W-1:0]  major_z;
        logic signed [COORD_W-1:0]  major_y;
        logic signed [COORD_W-1:0]  major_x;
        logic signed [COORD_W-1:0]  centre_z;
        logic signed [COORD_W-1:0]  centre_y;
        logic signed [COORD_W-1:0]  centre_x;
    } point_req_t;

    // result fields, voxel_x in the lowest bits, write enable from m_tuser on top
    typedef struct packed {
        logic                       write_enable;
        logic [COLOUR_W-1:0]        colour;
        logic signed [VOXEL_W-1:0]  z;
        logic signed [VOXEL_W-1:0]  y;
        logic signed [VOXEL_W-1:0]  x;
    } voxel_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [0:0]            m_tuser;

    voxel_t expected_voxels[$];
    int     n_sent;
    int     n_checked;
    int     n_written;
    int     n_errors;
    int     idle_cycles;
    int     stall_left;
    bit     send_gaps_on;
    bit     ready_stalls_on;

    ellipse_point_generator_3d_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    always #(CLK_HALF) aclk = ~aclk;

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // interpolated sine over the first quarter, x in 0..16384
    function automatic int quarter_wave(input int unsigned x);
        int unsigned k;
        int unsigned f;
        int          a;
        int          b;
        k = x >> 8;
        f = x & 32'hFF;
        if (k >= 64) return SINE_TAB[64];
        a = SINE_TAB[k];
        b = SINE_TAB[k + 1];
        return a + int'(((b - a) * f + 128) >> 8);
    endfunction

    // full wave by quadrant symmetry
    function automatic int wave_q15(input logic [PHASE_W-1:0] phase);
        int unsigned p;
        p = phase[13:0];
        case (phase[15:14])
            2'd0:    return quarter_wave(p);
            2'd1:    return quarter_wave(QUARTER_TURN - p);
            2'd2:    return -quarter_wave(p);
            default: return -quarter_wave(QUARTER_TURN - p);
        endcase
    endfunction

    // one coordinate: exact q.15 sum, truncated toward zero
    function automatic longint axis_point(input logic signed [COORD_W-1:0] ctr,
                                          input logic signed [COORD_W-1:0] maj,
                                          input logic signed [COORD_W-1:0] mnr,
                                          input int c, input int s);
        longint sum;
        sum = longint'(maj) * c + longint'(mnr) * s + longint'(ctr) * ONE_Q15;
        return sum / ONE_Q15;
    endfunction

    // expected voxel for one request
    function automatic voxel_t predict_voxel(input point_req_t req);
        int unsigned         idx;
        int unsigned         steps;
        logic [PHASE_W-1:0]  phase;
        int                  s;
        int                  c;
        longint              x;
        longint              y;
        longint              z;
        voxel_t              v;
        idx   = req.point_index % POINTS_DEF;
        steps = POINTS_DEF - 1 - idx;
        phase = PHASE_W'((steps * 65536 + POINTS_DEF / 2) / POINTS_DEF);
        s = wave_q15(phase);
        c = wave_q15(phase + PHASE_W'(QUARTER_TURN));
        x = axis_point(req.centre_x, req.major_x, req.minor_x, c, s);
        y = axis_point(req.centre_y, req.major_y, req.minor_y, c, s);
        z = axis_point(req.centre_z, req.major_z, req.minor_z, c, s);
        v.x = x[VOXEL_W-1:0];
        v.y = y[VOXEL_W-1:0];
        v.z = z[VOXEL_W-1:0];
        v.colour = req.colour;
        v.write_enable = x >= 0 && x < VOL_WIDTH_DEF && y >= 0 && y < VOL_HEIGHT_DEF &&
                         z >= 0 && z < VOL_DEPTH_DEF - 1;
        return v;
    endfunction

    function automatic point_req_t make_point(input int cx, input int cy, input int cz,
                                              input int ax, input int ay, input int az,
                                              input int bx, input int by, input int bz,
                                              input int colour, input int idx);
        point_req_t r;
        r.centre_x = COORD_W'(cx);
        r.centre_y = COORD_W'(cy);
        r.centre_z = COORD_W'(cz);
        r.major_x  = COORD_W'(ax);
        r.major_y  = COORD_W'(ay);
        r.major_z  = COORD_W'(az);
        r.minor_x  = COORD_W'(bx);
        r.minor_y  = COORD_W'(by);
        r.minor_z  = COORD_W'(bz);
        r.colour   = COLOUR_W'(colour);
        r.point_index = INDEX_W'(idx);
        return r;
    endfunction

    // random request: near the volume or anywhere in the field ranges
    function automatic point_req_t random_point(input bit near);
        point_req_t r;
        r = point_req_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
        if (near) begin
            r.centre_x = COORD_W'($urandom_range(0, 255));
            r.centre_y = COORD_W'($urandom_range(0, 255));
            r.centre_z = COORD_W'($urandom_range(0, 255));
            r.major_x  = COORD_W'(int'($urandom_range(0, 256)) - 128);
            r.major_y  = COORD_W'(int'($urandom_range(0, 256)) - 128);
            r.major_z  = COORD_W'(int'($urandom_range(0, 256)) - 128);
            r.minor_x  = COORD_W'(int'($urandom_range(0, 256)) - 128);
            r.minor_y  = COORD_W'(int'($urandom_range(0, 256)) - 128);
            r.minor_z  = COORD_W'(int'($urandom_range(0, 256)) - 128);
        end
        if ($urandom_range(0, 9) == 0)
            r.point_index = INDEX_W'($urandom_range(POINTS_DEF, 127));
        else
            r.point_index = INDEX_W'($urandom_range(0, POINTS_DEF - 1));
        return r;
    endfunction

    // send one request, with an optional gap before it
    task automatic send_point(input point_req_t req);
        int gap;
        gap = send_gaps_on ? pick_gap() : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(req);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_voxels.push_back(predict_voxel(req));
        n_sent++;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endtask

    // field extremes and the four quarter-turn angles
    task automatic test_extremes();
        send_point(make_point(-4096, -4096, -4096, -4096, -4096, -4096,
                              -4096, -4096, -4096, 0, 0));
        send_point(make_point(4095, 4095, 4095, 4095, 4095, 4095,
                              4095, 4095, 4095, 255, 127));
        foreach (SINE_TAB[k]) begin
            if (k < 4)
                send_point(make_point(-4096, 4095, 0, 4095, -4096, 4095,
                                      -4096, 4095, -4096, 17 * k, 25 * k + 24));
        end
    endtask

    // index at both ends of its range and beyond the point count
    task automatic test_index_wrap();
        send_point(make_point(128, 128, 128, 100, -50, 30, 50, 100, -30, 1, 0));
        send_point(make_point(128, 128, 128, 100, -50, 30, 50, 100, -30, 2, POINTS_DEF - 1));
        send_point(make_point(128, 128, 128, 100, -50, 30, 50, 100, -30, 3, POINTS_DEF));
        send_point(make_point(128, 128, 128, 100, -50, 30, 50, 100, -30, 4, 127));
    endtask

    // points on and just past each face of the volume, incl. the last depth plane
    task automatic test_volume_bounds();
        send_point(make_point(0, 0, 0, 0, 0, 0, 0, 0, 0, 10, 5));
        send_point(make_point(255, 255, 254, 0, 0, 0, 0, 0, 0, 11, 5));
        send_point(make_point(255, 255, 255, 0, 0, 0, 0, 0, 0, 12, 5));
        send_point(make_point(256, 0, 0, 0, 0, 0, 0, 0, 0, 13, 5));
        send_point(make_point(0, 256, 0, 0, 0, 0, 0, 0, 0, 14, 5));
        send_point(make_point(-1, 0, 0, 0, 0, 0, 0, 0, 0, 15, 5));
        send_point(make_point(0, -1, 0, 0, 0, 0, 0, 0, 0, 16, 5));
        send_point(make_point(0, 0, -1, 0, 0, 0, 0, 0, 0, 17, 5));
        send_point(make_point(0, 0, 256, 0, 0, 0, 0, 0, 0, 18, 5));
        // small fractions either side of zero truncate to zero
        send_point(make_point(0, 0, 0, -1, 0, 0, 0, 0, 0, 19, POINTS_DEF - 1));
        send_point(make_point(0, 0, 0, 1, 0, 0, 0, -1, 0, 20, 40));
    endtask

    // random points in blocks, idling switched per block
    task automatic test_random_points();
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 100 == 0) begin
                send_gaps_on    = $urandom_range(0, 3) != 0;
                ready_stalls_on = $urandom_range(0, 3) != 0;
            end
            send_point(random_point($urandom_range(0, 9) < 6));
        end
    endtask

    // result side: random stalls on m_tready
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            m_tready <= 1'b1;
            if (ready_stalls_on) stall_left = pick_gap();
        end
    end

    // compare each result with the oldest expected voxel
    always @(posedge aclk) begin
        voxel_t got;
        voxel_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = voxel_t'({m_tuser, m_tdata[VOXEL_BITS-1:0]});
            if (expected_voxels.size() == 0) begin
                $error("result with no request outstanding: %h", got);
                n_errors++;
            end else begin
                want = expected_voxels.pop_front();
                check_field("voxel_x", want.x, got.x);
                check_field("voxel_y", want.y, got.y);
                check_field("voxel_z", want.z, got.z);
                check_field("voxel_colour", want.colour, got.colour);
                check_field("write_enable", want.write_enable, got.write_enable);
                n_checked++;
                if (got.write_enable) n_written++;
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     idle_cycles, expected_voxels.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // sequence of tests
    initial begin
        aclk            = 1'b0;
        aresetn         = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        m_tready        = 1'b0;
        n_sent          = 0;
        n_checked       = 0;
        n_written       = 0;
        n_errors        = 0;
        idle_cycles     = 0;
        stall_left      = 0;
        send_gaps_on    = 1'b1;
        ready_stalls_on = 1'b1;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_extremes();
        test_index_wrap();
        test_volume_bounds();
        test_random_points();

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_voxels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d points sent, %0d results checked, %0d inside the volume",
                 n_sent, n_checked, n_written);
        $display("covered field extremes, index wrap, volume faces and random idling");
        if (n_errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
